// ----- src/parent_forest_validator_assert.svh -----
// ---------------------------------------------------------------------------
// Parent forest validator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off in reset.
// ---------------------------------------------------------------------------
`ifndef PARENT_FOREST_VALIDATOR_ASSERT_SVH
`define PARENT_FOREST_VALIDATOR_ASSERT_SVH

// same-cycle implication
`define PFV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pfv_pkg.sv -----
// ---------------------------------------------------------------------------
// Parent forest validator package
// Field widths and result cause codes.
// ---------------------------------------------------------------------------
package pfv_pkg;

  localparam int ParentW = 16;
  localparam int CauseW  = 3;
  localparam int TotalW  = 9;

  typedef logic signed [ParentW-1:0] parent_t;
  typedef logic [TotalW-1:0]         total_t;

  typedef enum logic [CauseW-1:0] {
    CAUSE_OK       = 3'd0,
    CAUSE_RANGE    = 3'd1,
    CAUSE_NO_ROOT  = 3'd2,
    CAUSE_CYCLE    = 3'd3,
    CAUSE_TOO_MANY = 3'd4
  } cause_e;

endpackage

// ----- src/pfv_ram.sv -----
// ---------------------------------------------------------------------------
// Parent forest validator RAM
// Generic one-write, one-read memory with registered read data.
// ---------------------------------------------------------------------------
module pfv_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/parent_forest_validator.sv -----
// ---------------------------------------------------------------------------
// Parent forest validator
// Loads a skeleton parent table one bone per request, flags overflow past MAX_BONES,
// then checks range, root presence and acyclic parent chains from the stored table.
// ---------------------------------------------------------------------------
//  channel | direction | signals
//  in      | sink      | in_valid_i, in_stall_o, parent_index_i, carries_bone_i,
//          |           | last_bone_i
//  out     | source    | out_valid_o, out_stall_i, hierarchy_ok_o, failure_cause_o,
//          |           | total_bones_o, total_roots_o
//
// Load: one request per cycle while not stalled; the parent store takes
// one write per cycle. Check: a read state and a check state per bone for
// the range scan, then per hop of every chain walk, via the single read
// port and its registered read data; input stalls during the check.
// Reset clears control state only; the store needs no clearing pass.
// A waiting result does not block loading of the next skeleton.
// ---------------------------------------------------------------------------
module parent_forest_validator #(
  parameter int MAX_BONES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pfv_pkg::parent_t parent_index_i,
  input  logic             carries_bone_i,
  input  logic             last_bone_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             hierarchy_ok_o,
  output logic [2:0]       failure_cause_o,
  output pfv_pkg::total_t  total_bones_o,
  output pfv_pkg::total_t  total_roots_o
);
  import pfv_pkg::*;

  localparam int CntW  = $clog2(MAX_BONES + 1);
  localparam int AddrW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int CmpW  = CntW + ParentW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BONES);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RANGE_RD,
    ST_RANGE_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] bone_cnt_q, bone_cnt_d;
  logic [CntW-1:0] root_cnt_q, root_cnt_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic [CntW:0]   hops_q, hops_d;
  cause_e          cause_q, cause_d;
  logic            out_valid_q, out_valid_d;
  logic            ok_q, ok_d;
  logic [2:0]      cause_out_q, cause_out_d;
  total_t          tb_q, tb_d;
  total_t          tr_q, tr_d;

  logic            in_acc;
  logic            store_bone;
  logic            ram_we;
  logic [AddrW-1:0] ram_raddr;
  parent_t         ram_rdata;
  logic [CntW+TotalW-1:0] bones_ext, roots_ext;
  logic [CntW:0]   hops_inc;
  logic            idx_last;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_bone = carries_bone_i && (bone_cnt_q < MaxCnt);
  assign ram_we     = in_acc && store_bone;
  assign ram_raddr  = (state_q == ST_WALK_RD) ? cur_q : idx_q[AddrW-1:0];
  assign bones_ext  = {{TotalW{1'b0}}, bone_cnt_q};
  assign roots_ext  = {{TotalW{1'b0}}, root_cnt_q};
  assign hops_inc   = hops_q + 1'b1;
  assign idx_last   = ((idx_q + 1'b1) == bone_cnt_q);

  pfv_ram #(
    .Width (ParentW),
    .Depth (MAX_BONES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bone_cnt_q[AddrW-1:0]),
    .wdata_i (parent_index_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    bone_cnt_d  = bone_cnt_q;
    root_cnt_d  = root_cnt_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    hops_d      = hops_q;
    cause_d     = cause_q;
    out_valid_d = out_valid_q && out_stall_i;
    ok_d        = ok_q;
    cause_out_d = cause_out_q;
    tb_d        = tb_q;
    tr_d        = tr_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (store_bone) begin
            bone_cnt_d = bone_cnt_q + 1'b1;
            if (parent_index_i[ParentW-1]) begin
              root_cnt_d = root_cnt_q + 1'b1;
            end
          end else if (carries_bone_i) begin
            ovf_d = 1'b1;
          end
          if (last_bone_i) begin
            idx_d = '0;
            if (ovf_d) begin
              cause_d = CAUSE_TOO_MANY;
              state_d = ST_DONE;
            end else if (bone_cnt_d == '0) begin
              cause_d = CAUSE_OK;
              state_d = ST_DONE;
            end else begin
              state_d = ST_RANGE_RD;
            end
          end
        end
      end
      ST_RANGE_RD: begin
        state_d = ST_RANGE_CHK;
      end
      ST_RANGE_CHK: begin
        if (!ram_rdata[ParentW-1] &&
            (CmpW'(ram_rdata[ParentW-2:0]) >= CmpW'(bone_cnt_q))) begin
          cause_d = CAUSE_RANGE;
          state_d = ST_DONE;
        end else if (idx_last) begin
          if (root_cnt_q == '0) begin
            cause_d = CAUSE_NO_ROOT;
            state_d = ST_DONE;
          end else begin
            idx_d   = '0;
            cur_d   = '0;
            hops_d  = '0;
            state_d = ST_WALK_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_RANGE_RD;
        end
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (hops_inc > (CntW + 1)'(bone_cnt_q)) begin
          cause_d = CAUSE_CYCLE;
          state_d = ST_DONE;
        end else if (ram_rdata[ParentW-1]) begin
          if (idx_last) begin
            cause_d = CAUSE_OK;
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            cur_d   = idx_d[AddrW-1:0];
            hops_d  = '0;
            state_d = ST_WALK_RD;
          end
        end else begin
          cur_d   = ram_rdata[AddrW-1:0];
          hops_d  = hops_inc;
          state_d = ST_WALK_RD;
        end
      end
      ST_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          ok_d        = (cause_q == CAUSE_OK);
          cause_out_d = cause_q;
          tb_d        = bones_ext[TotalW-1:0];
          tr_d        = roots_ext[TotalW-1:0];
          bone_cnt_d  = '0;
          root_cnt_d  = '0;
          ovf_d       = 1'b0;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      bone_cnt_q  <= '0;
      root_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      cur_q       <= '0;
      hops_q      <= '0;
      cause_q     <= CAUSE_OK;
    end else begin
      state_q     <= state_d;
      bone_cnt_q  <= bone_cnt_d;
      root_cnt_q  <= root_cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      cur_q       <= cur_d;
      hops_q      <= hops_d;
      cause_q     <= cause_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q        <= ok_d;
    cause_out_q <= cause_out_d;
    tb_q        <= tb_d;
    tr_q        <= tr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign hierarchy_ok_o  = ok_q;
  assign failure_cause_o = cause_out_q;
  assign total_bones_o   = tb_q;
  assign total_roots_o   = tr_q;

`include "parent_forest_validator_assert.svh"

  `PFV_ASSERT_NOW(a_ok_matches_cause, out_valid_q, ok_q == (cause_out_q == CAUSE_OK), "bad ok")
  `PFV_ASSERT_NEXT(a_last_starts_check, in_acc && last_bone_i, in_stall_o, "no stall after last")
  `PFV_ASSERT_NOW(a_roots_bounded, 1'b1, root_cnt_q <= bone_cnt_q, "root count above bone count")
  `PFV_ASSERT_NOW(a_bones_bounded, 1'b1, bone_cnt_q <= MaxCnt, "bone count above capacity")
  `PFV_ASSERT_NOW(a_hops_bounded, state_q == ST_WALK_RD, hops_q <= {1'b0, bone_cnt_q}, "hops")

endmodule

// ----- sim/tb_parent_forest_validator.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Parent forest validator testbench
// Feeds skeleton parent tables through the request channel, predicts each
// verdict (range, root presence, chain cycles, oversize) in a local shadow
// of the table, and compares every result field under random idling and
// result back-pressure.
// ---------------------------------------------------------------------------
module tb_parent_forest_validator;
  import pfv_pkg::*;

  localparam int BoneCap       = 256;
  localparam int TargetReqs    = 1450;
  localparam int TailReqs      = 150;
  localparam int LongHold      = 400;
  localparam int WatchdogLimit = 600000;

  typedef enum int {
    FLAW_NONE,
    FLAW_RANGE,
    FLAW_NO_ROOT,
    FLAW_CYCLE,
    FLAW_SCRAMBLE,
    FLAW_CHAIN,
    FLAW_ALL_ROOTS
  } flaw_e;

  typedef struct {
    parent_t parent;
    logic    carries;
    logic    is_last;
  } bone_req_t;

  typedef struct {
    logic   ok;
    cause_e cause;
    total_t bones;
    total_t roots;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  parent_t    parent_index_i = '0;
  logic       carries_bone_i = 1'b0;
  logic       last_bone_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       hierarchy_ok_o;
  logic [2:0] failure_cause_o;
  total_t     total_bones_o;
  total_t     total_roots_o;

  bone_req_t  pending_reqs[$];
  verdict_t   pending_verdicts[$];
  verdict_t   want;

  parent_t    shadow_parents[BoneCap];
  int         shadow_bones = 0;
  int         shadow_roots = 0;
  bit         shadow_overflow = 1'b0;

  int         reqs_queued = 0;
  int         reqs_accepted = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         cause_hits[5] = '{default: 0};
  int         in_gap = 0;
  int         hold_left = 0;
  int         held_at = -1;
  int         quiet_cycles = 0;
  logic       tail_phase = 1'b0;

  parent_forest_validator #(
    .MAX_BONES(BoneCap)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .parent_index_i (parent_index_i),
    .carries_bone_i (carries_bone_i),
    .last_bone_i    (last_bone_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hierarchy_ok_o (hierarchy_ok_o),
    .failure_cause_o(failure_cause_o),
    .total_bones_o  (total_bones_o),
    .total_roots_o  (total_roots_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic cause_e forest_cause();
    int n;
    int cur;
    int hops;
    n = shadow_bones;
    if (shadow_overflow) return CAUSE_TOO_MANY;
    if (n == 0) return CAUSE_OK;
    for (int i = 0; i < n; i++) begin
      if (int'(shadow_parents[i]) >= n) return CAUSE_RANGE;
    end
    if (shadow_roots == 0) return CAUSE_NO_ROOT;
    for (int i = 0; i < n; i++) begin
      cur = i;
      hops = 0;
      while (cur >= 0) begin
        cur = int'(shadow_parents[cur]);
        hops++;
        if (hops > n) return CAUSE_CYCLE;
      end
    end
    return CAUSE_OK;
  endfunction

  task automatic load_bone_request(parent_t p, logic carries, logic is_last);
    verdict_t v;
    if (carries) begin
      if (shadow_bones < BoneCap) begin
        shadow_parents[shadow_bones] = p;
        shadow_bones++;
        if (p < 0) shadow_roots++;
      end else begin
        shadow_overflow = 1'b1;
      end
    end
    if (is_last) begin
      v.cause = forest_cause();
      v.ok    = (v.cause == CAUSE_OK);
      v.bones = total_t'(shadow_bones);
      v.roots = total_t'(shadow_roots);
      pending_verdicts.push_back(v);
      shadow_bones    = 0;
      shadow_roots    = 0;
      shadow_overflow = 1'b0;
    end
  endtask

  function automatic parent_t root_parent();
    int mag;
    mag = $urandom_range(1, 32768);
    return parent_t'(-mag);
  endfunction

  function automatic parent_t any_parent();
    return parent_t'($urandom_range(0, 65535));
  endfunction

  task automatic push_req(parent_t p, logic carries, logic is_last);
    pending_reqs.push_back('{parent: p, carries: carries, is_last: is_last});
    if (carries || is_last) reqs_queued++;
  endtask

  task automatic queue_skeleton(int n, flaw_e flaw, bit marker_end, bit noisy);
    parent_t par[];
    int      ord[];
    int      j;
    int      tmp;
    int      x;
    int      hops;
    par = new[n];
    ord = new[n];
    for (int k = 0; k < n; k++) ord[k] = k;
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = ord[k];
      ord[k] = ord[j];
      ord[j] = tmp;
    end
    for (int k = 0; k < n; k++) begin
      if (k == 0 || flaw == FLAW_ALL_ROOTS) par[ord[k]] = root_parent();
      else if (flaw == FLAW_CHAIN) par[ord[k]] = parent_t'(ord[k-1]);
      else if ($urandom_range(0, 7) == 0) par[ord[k]] = root_parent();
      else par[ord[k]] = parent_t'(ord[$urandom_range(0, k - 1)]);
    end
    if (n > 0) begin
      case (flaw)
        FLAW_RANGE: begin
          x = $urandom_range(0, n - 1);
          par[x] = $urandom_range(0, 1) ? parent_t'(n) : parent_t'($urandom_range(n, 32767));
        end
        FLAW_NO_ROOT: begin
          for (int k = 0; k < n; k++) par[k] = parent_t'($urandom_range(0, n - 1));
        end
        FLAW_CYCLE: begin
          x = $urandom_range(0, n - 1);
          j = x;
          hops = $urandom_range(0, n);
          while (hops > 0 && par[j] >= 0) begin
            j = int'(par[j]);
            hops--;
          end
          par[j] = parent_t'(x);
        end
        FLAW_SCRAMBLE: begin
          for (int k = 0; k < n; k++) begin
            par[k] = ($urandom_range(0, 5) == 0) ? root_parent()
                                                : parent_t'($urandom_range(0, n - 1));
          end
        end
        default: ;
      endcase
    end
    for (int k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 5) == 0) push_req(any_parent(), 1'b0, 1'b0);
      push_req(par[k], 1'b1, !marker_end && k == n - 1);
    end
    if (marker_end || n == 0) push_req(any_parent(), 1'b0, 1'b1);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
      tail_phase <= 1'b0;
    end else begin
      tail_phase <= (pending_reqs.size() < TailReqs);
      if (in_valid_i && !in_stall_o) begin
        load_bone_request(parent_index_i, carries_bone_i, last_bone_i);
        reqs_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!tail_phase && (reqs_accepted / 128) % 3 != 1 &&
                     $urandom_range(0, 5) == 0) begin
          in_gap     <= $urandom_range(0, 7);
          in_valid_i <= 1'b0;
        end else begin
          parent_index_i <= pending_reqs[0].parent;
          carries_bone_i <= pending_reqs[0].carries;
          last_bone_i    <= pending_reqs[0].is_last;
          in_valid_i     <= 1'b1;
          pending_reqs.delete(0);
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          $error("result with no pending skeleton: ok=%0d cause=%0d bones=%0d roots=%0d",
                 hierarchy_ok_o, failure_cause_o, total_bones_o, total_roots_o);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (hierarchy_ok_o !== want.ok) begin
            $error("hierarchy_ok: expected %0d, got %0d", want.ok, hierarchy_ok_o);
            mismatches++;
          end
          if (failure_cause_o !== want.cause) begin
            $error("failure_cause: expected %0d, got %0d", want.cause, failure_cause_o);
            mismatches++;
          end
          if (total_bones_o !== want.bones) begin
            $error("total_bones: expected %0d, got %0d", want.bones, total_bones_o);
            mismatches++;
          end
          if (total_roots_o !== want.roots) begin
            $error("total_roots: expected %0d, got %0d", want.roots, total_roots_o);
            mismatches++;
          end
          cause_hits[int'(want.cause)]++;
          results_seen++;
        end
      end
      if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if ((results_seen == 5 || results_seen == 60) && held_at != results_seen) begin
        held_at     <= results_seen;
        hold_left   <= LongHold - 1;
        out_stall_i <= 1'b1;
      end else if (!tail_phase && (results_seen / 16) % 3 != 2 &&
                   $urandom_range(0, 4) == 0) begin
        hold_left   <= $urandom_range(0, 7);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $error("no handshake for %0d cycles", quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int    n;
    int    pick;
    bit    chain_done;
    bit    overflow_done;
    flaw_e flaw;
    chain_done    = 1'b0;
    overflow_done = 1'b0;

    push_req(parent_t'(16'h5555), 1'b0, 1'b0);
    push_req(parent_t'(16'hAAAA), 1'b0, 1'b1);
    push_req(parent_t'(-32768), 1'b1, 1'b1);
    push_req(parent_t'(0), 1'b1, 1'b1);
    push_req(parent_t'(32767), 1'b1, 1'b1);
    push_req(parent_t'(1), 1'b1, 1'b1);
    push_req(parent_t'(-1), 1'b1, 1'b0);
    push_req(parent_t'(2), 1'b1, 1'b0);
    push_req(parent_t'(1), 1'b1, 1'b1);
    push_req(parent_t'(5), 1'b1, 1'b0);
    push_req(parent_t'(0), 1'b1, 1'b1);
    push_req(parent_t'(-1), 1'b1, 1'b0);
    push_req(parent_t'(16'h7FFF), 1'b0, 1'b0);
    push_req(parent_t'(0), 1'b1, 1'b0);
    push_req(parent_t'(16'h8000), 1'b0, 1'b1);
    push_req(parent_t'(1), 1'b1, 1'b0);
    push_req(parent_t'(-2), 1'b1, 1'b0);
    push_req(parent_t'(1), 1'b1, 1'b1);

    while (reqs_queued < TargetReqs) begin
      if (reqs_queued > 200 && !chain_done) begin
        queue_skeleton(BoneCap, FLAW_CHAIN, 1'b0, 1'b0);
        chain_done = 1'b1;
      end else if (reqs_queued > 800 && !overflow_done) begin
        queue_skeleton(BoneCap + $urandom_range(1, 3), FLAW_ALL_ROOTS,
                       $urandom_range(0, 1), 1'b0);
        overflow_done = 1'b1;
      end else if ($urandom_range(0, 30) == 0) begin
        queue_skeleton(0, FLAW_NONE, 1'b1, 1'b0);
      end else begin
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        pick = $urandom_range(0, 99);
        if (pick < 40) flaw = FLAW_NONE;
        else if (pick < 52) flaw = FLAW_RANGE;
        else if (pick < 62) flaw = FLAW_NO_ROOT;
        else if (pick < 80) flaw = FLAW_CYCLE;
        else flaw = FLAW_SCRAMBLE;
        queue_skeleton(n, flaw, $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || pending_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d skeleton verdicts", reqs_accepted, results_seen);
    $display("Causes seen: ok %0d, range %0d, no root %0d, cycle %0d, too many %0d",
             cause_hits[CAUSE_OK], cause_hits[CAUSE_RANGE], cause_hits[CAUSE_NO_ROOT],
             cause_hits[CAUSE_CYCLE], cause_hits[CAUSE_TOO_MANY]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/pfv_pkg.sv
src/pfv_ram.sv
src/parent_forest_validator.sv
sim/tb_parent_forest_validator.sv
